@@ src/multi_reader_frame_ring_manager_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frame ring manager
// Each macro expands to a labeled concurrent assertion, or to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_FRAME_RING_MANAGER_UNIT_DEFINES_SVH
`define MULTI_READER_FRAME_RING_MANAGER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MRFR_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define MRFR_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define MRFR_ASSERT_IMP(label, clk, rst, a, c, msg)
`define MRFR_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

@@ src/mrfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfr_pkg
// Shared types, codes and defaults for the frame ring manager.
// ----------------------------------------------------------------------------
package mrfr_pkg;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MEM_BYTES_DEF   = 4096;
  localparam int NUM_READERS_DEF = 8;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_RDOLD  = 3'd1;
  localparam logic [2:0] CMD_RDNEW  = 3'd2;
  localparam logic [2:0] CMD_SET    = 3'd3;
  localparam logic [2:0] CMD_CLR    = 3'd4;
  localparam logic [2:0] CMD_CLEAN  = 3'd5;
  localparam logic [2:0] CMD_SCAN   = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INPUT   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_AGAIN   = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  localparam logic [0:0] REG_INIT_MASK = 1'd0;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] length;
    logic [3:0]  cursor;
    logic        cursor_default;
    logic [7:0]  reader_bits;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [11:0] data_addr;
    logic [12:0] data_len;
    logic [3:0]  next_cursor;
    logic [3:0]  oldest_index;
    logic [3:0]  newest_slot;
  } rsp_t;
endpackage

@@ src/mrfr_if.sv @@
// ----------------------------------------------------------------------------
// mrfr_req_if / mrfr_rsp_if
// Valid/ready channels carrying command and result transactions.
// ----------------------------------------------------------------------------
interface mrfr_req_if;
  import mrfr_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrfr_rsp_if;
  import mrfr_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/mrfr_ram.sv @@
// ----------------------------------------------------------------------------
// mrfr_ram
// Generic simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mrfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/multi_reader_frame_ring_manager_unit.sv @@
// ----------------------------------------------------------------------------
// multi_reader_frame_ring_manager_unit
// Descriptor ring over a byte store with per-frame pending reader masks.
// ----------------------------------------------------------------------------
// One command transaction in, one result transaction out. Descriptor address
// and length live in a synchronous RAM. Valid and pending bits sit in flip-
// flops, which are cleared by reset and by clean. Commands run one at a time
// on a small sequencer. A write first evicts the head descriptor while the
// ring is full, and is stored as soon as it fits. Until then it wraps to the
// start of the byte store on an empty ring, or reads the head descriptor
// from the RAM to reclaim its space. A scan passes over invalid descriptors
// until it finds a valid one or reaches the tail.
// The result goes to its own output register, so the next command is taken
// while that result still waits. A command that finishes while the output
// register is still full holds in its last step until the register is taken.
module multi_reader_frame_ring_manager_unit
  import mrfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MEM_BYTES   = MEM_BYTES_DEF,
  parameter int NUM_READERS = NUM_READERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mrfr_req_if.sink    req,
  mrfr_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "multi_reader_frame_ring_manager_unit_defines.svh"

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int AW = $clog2(MEM_BYTES + 1);
  localparam int LW = 13;
  localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0] MEMB = AW'(MEM_BYTES);
  localparam logic [7:0] KEEP = 8'((33'h1 << NUM_READERS) - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,  // command decoded, read address chosen
    S_RDW   = 7'b0000100,  // RAM read address issued
    S_WCHK  = 7'b0001000,  // write loop step
    S_WHEAD = 7'b0010000,  // head descriptor data back
    S_SCAN  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  req_t   cur;
  rsp_t   res;
  rsp_t   rsp_q;
  logic   out_full;
  logic [7:0] init_mask, live_mask;
  logic [QUEUE_DEPTH-1:0] valid_bits;
  logic [7:0] pend [QUEUE_DEPTH];
  logic [IW-1:0] head, tail, item;
  logic [AW-1:0] wpos, wlim;
  logic [5:0]  guard;
  logic [IW:0] steps;

  // descriptor RAM: {addr, length}
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [AW+LW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0] r_addr;
  logic [LW-1:0] r_len;
  assign r_addr = ram_rdata[AW+LW-1:LW];
  assign r_len  = ram_rdata[LW-1:0];

  mrfr_ram #(.WIDTH(AW + LW), .DEPTH(QUEUE_DEPTH)) u_desc (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  assign pready = 1'b1;
  assign prdata = {24'd0, init_mask};
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_full;
  assign rsp.data  = rsp_q;

  logic [7:0] bits;
  assign bits = cur.reader_bits & KEEP;
  logic fits, ring_full;
  assign fits = ({1'b0, wlim} >= {1'b0, wpos} + (AW+1)'(cur.length));
  assign ring_full = (nxt(tail) == head);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = tail;
    ram_wdata = {wpos, cur.length};
    ram_raddr = item;
    if (state == S_WCHK && !ring_full && fits && !(wpos > MEMB)) begin
      ram_we = 1'b1;
    end
    if (state == S_WCHK) ram_raddr = head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      init_mask <= '0;
      live_mask <= '0;
      valid_bits <= '0;
      head <= '0;
      tail <= '0;
      wpos <= '0;
      wlim <= MEMB;
      for (int k = 0; k < QUEUE_DEPTH; k++) pend[k] <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == {1'b0, REG_INIT_MASK})
        init_mask <= pwdata[7:0];
      if (rsp.valid && rsp.ready) out_full <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid) begin
          cur <= req.data;
          guard <= '0;
          steps <= '0;
          res <= '0;
          state <= S_RD;
        end
        S_RD: begin
          res.status <= ST_OK;
          state <= S_OUT;
          case (cur.cmd)
            CMD_WRITE: begin
              if (cur.length > LW'(MEM_BYTES)) res.status <= ST_INPUT;
              else state <= S_WCHK;
            end
            CMD_RDOLD, CMD_RDNEW: begin
              if (cur.cursor_default)
                item <= (cur.cmd == CMD_RDOLD) ? head : ((tail == '0) ? LAST : tail - 1'b1);
              else item <= IW'(cur.cursor);
              if (!cur.cursor_default && 32'(cur.cursor) >= QUEUE_DEPTH)
                res.status <= ST_INVALID;
              else state <= S_RDW;
            end
            CMD_SET: live_mask <= (live_mask | bits) & KEEP;
            CMD_CLR: live_mask <= live_mask & ~bits;
            CMD_CLEAN: begin
              wpos <= '0; wlim <= MEMB; head <= '0; tail <= '0;
              live_mask <= init_mask & KEEP;
              valid_bits <= '0;
              for (int k = 0; k < QUEUE_DEPTH; k++) pend[k] <= '0;
            end
            CMD_SCAN: begin
              item <= cur.cursor_default ? head : IW'(cur.cursor);
              if (!cur.cursor_default && 32'(cur.cursor) >= QUEUE_DEPTH)
                res.status <= ST_INVALID;
              else state <= S_SCAN;
            end
            default: res.status <= ST_INPUT;
          endcase
        end
        S_SCAN: begin
          if (item == tail || 32'(steps) >= QUEUE_DEPTH) begin
            res.status <= ST_AGAIN;
            state <= S_OUT;
          end else if (valid_bits[item]) begin
            state <= S_RDW;  // ram_raddr = item this cycle
          end else begin
            item <= nxt(item);
            steps <= steps + 1'b1;
          end
        end
        S_RDW: begin
          // data for item arrives next cycle; reuse S_WHEAD-less path
          state <= S_OUT;
          if (cur.cmd != CMD_SCAN) begin
            if (item == tail) res.status <= ST_AGAIN;
            else if (!valid_bits[item]) res.status <= ST_INVALID;
          end
          guard[0] <= 1'b1;  // marks pending fill of read fields
        end
        S_WCHK: begin
          if (guard >= 6'd63) begin
            res.status <= ST_FULL; state <= S_OUT;
          end else if (ring_full && pend[head] != '0) begin
            res.status <= ST_FULL; state <= S_OUT;
          end else if (ring_full) begin
            valid_bits[head] <= 1'b0;
            head <= nxt(head);
            guard <= guard + 1'b1;
          end else if (fits) begin
            res.entry_index <= 4'(tail);
            res.data_addr <= 12'(wpos);
            res.data_len <= cur.length;
            res.next_cursor <= 4'(nxt(tail));
            pend[tail] <= live_mask;
            valid_bits[tail] <= 1'b1;
            tail <= nxt(tail);
            wpos <= wpos + AW'(cur.length);
            state <= S_OUT;
          end else if (head == tail) begin
            wpos <= '0; wlim <= MEMB; guard <= guard + 1'b1;
          end else begin
            state <= S_WHEAD;
          end
        end
        S_WHEAD: begin
          state <= S_WCHK;
          guard <= guard + 1'b1;
          if (wpos > r_addr && wlim != MEMB) begin
            wlim <= MEMB;
          end else if (pend[head] != '0) begin
            res.status <= ST_FULL; state <= S_OUT;
          end else begin
            wlim <= r_addr + AW'(r_len);
            valid_bits[head] <= 1'b0;
            head <= nxt(head);
            if (wpos > r_addr) wpos <= '0;
          end
        end
        S_OUT: begin
          if (guard[0] && cur.cmd != CMD_WRITE && res.status == ST_OK) begin
            res.entry_index <= 4'(item);
            res.data_addr <= 12'(r_addr);
            res.data_len <= (cur.cmd != CMD_SCAN && cur.length < r_len)
                            ? cur.length : r_len;
            res.next_cursor <= 4'(nxt(item));
            if (cur.cmd != CMD_SCAN) pend[item] <= pend[item] & ~bits;
            guard[0] <= 1'b0;
          end else if (!out_full || rsp.ready) begin
            // hand the finished transaction to the output register
            rsp_q <= {res.status, res.entry_index, res.data_addr, res.data_len,
                      res.next_cursor, 4'(head), 4'(tail)};
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MRFR_ASSERT_IMP(a_ready_idle, clk, rst, req.ready, state == S_IDLE, "ready outside idle")
  `MRFR_ASSERT_NXT(a_out_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
  `MRFR_ASSERT_IMP(a_wr_ok_valid, clk, rst, ram_we, !valid_bits[tail] || head != tail,
                   "write over live descriptor")
endmodule
